[hdl/xrg_pkg.sv]
package xrg_pkg;

  typedef enum logic [2:0] {
    CMD_RAW   = 3'd0,
    CMD_RANGE = 3'd1,
    CMD_JUMP  = 3'd2,
    CMD_LJUMP = 3'd3,
    CMD_SEED  = 3'd4
  } cmd_t;

  localparam logic [63:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] SM_MUL1  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] SM_MUL2  = 64'h94d049bb133111eb;

  localparam logic [255:0] JUMP_POLY = {64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
                                        64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba};
  localparam logic [255:0] LJUMP_POLY = {64'h39109bb02acbe635, 64'h77710069854ee241,
                                         64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf};

  // request to the multiplier
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  // answer of the multiplier
  typedef struct packed {
    logic         done;
    logic [127:0] prod;
  } mul_rsp_t;

endpackage

[hdl/xrg_mul.sv]
// 64x64 -> 128 multiplier, one 32x32 partial product per cycle
module xrg_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  xrg_pkg::mul_req_t req,
  output xrg_pkg::mul_rsp_t rsp
);
  logic [63:0]  a_r, b_r;
  logic [127:0] acc_r;
  logic [2:0]   step_r;
  logic         busy_r, done_r;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;

  // operand pick for this step
  always_comb begin
    pa = step_r[1] ? a_r[63:32] : a_r[31:0];
    pb = step_r[0] ? b_r[63:32] : b_r[31:0];
    pp = {32'd0, pa} * {32'd0, pb};
    pp_sh = {64'd0, pp} << ({5'd0, step_r[1]} + {5'd0, step_r[0]}) * 32;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        a_r    <= req.a;
        b_r    <= req.b;
        acc_r  <= '0;
        step_r <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r  <= acc_r + pp_sh;
        step_r <= step_r + 3'd1;
        if (step_r == 3'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;
endmodule

[hdl/xrg_div.sv]
// 64-bit restoring remainder, one bit per cycle (used for (-bound) % bound)
module xrg_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] rem
);
  logic [63:0] n_r, d_r;
  logic [64:0] r_r;
  logic [6:0]  cnt_r;
  logic        busy_r, done_r;
  logic [64:0] trial;

  always_comb trial = {r_r[63:0], n_r[63]} - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        n_r    <= num;
        d_r    <= den;
        r_r    <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        n_r <= {n_r[62:0], 1'b0};
        r_r <= trial[64] ? {r_r[63:0], n_r[63]} : trial;
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = r_r[63:0];
endmodule

[hdl/xoshiro_random_generator_unit.sv]
// xoshiro256** generator with a sequencer around one shared 64x64 multiplier
// (four 32x32 partial products, one a cycle) and a bit-serial remainder unit.
// Results go to an output register, so in_stall drops as soon as the result is
// loaded there, unless an earlier result is still waiting. A raw draw makes two
// multiplier passes, for *5 and *9; the next request can be taken in the cycle
// the result appears. A ranged draw with an empty range or a span of one, and
// an unknown command, go straight to the output register. A ranged draw needs
// the remainder pass only when the low product half falls below the bound; each
// rejected sample starts a new draw. Jump and long jump step the state through
// the bits of the jump polynomial, folding the state in for every set bit, then
// load the accumulated state. Reseed runs eight multiplier passes; after reset
// the same expansion keeps in_stall high until it is done. Output stalls hold
// the sequencer in its output state once the output register is full.
module xoshiro_random_generator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [63:0] in_range_low,
  input  logic [63:0] in_range_high,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_value
);
  typedef enum logic [3:0] {
    S_IDLE, S_SM_C, S_SM_A, S_SM_B, S_DR1, S_DR2, S_RMUL, S_RDIV,
    S_JUMP, S_OUT
  } state_t;

  state_t            state_r;
  logic [63:0]       w0_r, w1_r, w2_r, w3_r, a0_r, a1_r, a2_r, a3_r;
  logic [63:0]       seed_r, acc_r, lo_r, bound_r, res_r, tmp_r, out_r;
  logic              out_valid_r;
  logic [2:0]        cmd_r;
  logic [1:0]        idx_r;
  logic [7:0]        bit_r;
  logic              long_r;
  xrg_pkg::mul_req_t mreq;
  xrg_pkg::mul_rsp_t mrsp;
  logic              dstart, ddone;
  logic [63:0]       drem, neg_bound, span, sm_first, sm_next;
  logic [63:0]       n0, n1, n2, n3, t17, z;
  logic              pbit, accept, span_ok, span_one;

  xrg_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
  xrg_div u_div (.clk(clk), .rst_n(rst_n), .start(dstart), .num(neg_bound),
                 .den(bound_r), .done(ddone), .rem(drem));

  // request decode and splitmix64 operands
  assign accept    = in_valid && !in_stall;
  assign span      = in_range_high - in_range_low;
  assign span_one  = (in_range_high > in_range_low) && (span == 64'd1);
  assign span_ok   = (in_range_high > in_range_low) && (span != 64'd1);
  assign neg_bound = 64'd0 - bound_r;
  assign sm_first  = (seed_r + xrg_pkg::SM_GAMMA) ^ ((seed_r + xrg_pkg::SM_GAMMA) >> 30);
  assign sm_next   = (acc_r + xrg_pkg::SM_GAMMA) ^ ((acc_r + xrg_pkg::SM_GAMMA) >> 30);

  // one xoshiro state step
  always_comb begin
    t17 = w1_r << 17;
    n2 = w2_r ^ w0_r;
    n3 = w3_r ^ w1_r;
    n1 = w1_r ^ n2;
    n0 = w0_r ^ n3;
    n2 = n2 ^ t17;
    n3 = {n3[18:0], n3[63:19]};
    pbit = long_r ? xrg_pkg::LJUMP_POLY[bit_r] : xrg_pkg::JUMP_POLY[bit_r];
    z = mrsp.prod[63:0];
  end

  // multiplier and remainder requests
  always_comb begin
    mreq   = '0;
    dstart = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_command == xrg_pkg::CMD_RAW ||
            (in_command == xrg_pkg::CMD_RANGE && span_ok))) begin
          mreq.start = 1'b1; mreq.a = w1_r; mreq.b = 64'd5;
        end
      end
      S_SM_C: begin
        mreq.start = 1'b1; mreq.a = sm_first; mreq.b = xrg_pkg::SM_MUL1;
      end
      S_SM_A: if (mrsp.done) begin
        mreq.start = 1'b1; mreq.a = z ^ (z >> 27); mreq.b = xrg_pkg::SM_MUL2;
      end
      S_SM_B: if (mrsp.done && idx_r != 2'd3) begin
        mreq.start = 1'b1; mreq.a = sm_next; mreq.b = xrg_pkg::SM_MUL1;
      end
      S_DR1: if (mrsp.done) begin
        mreq.start = 1'b1; mreq.a = {z[56:0], z[63:57]}; mreq.b = 64'd9;
      end
      S_DR2: if (mrsp.done && cmd_r == xrg_pkg::CMD_RANGE) begin
        mreq.start = 1'b1; mreq.a = z; mreq.b = bound_r;
      end
      S_RMUL: if (mrsp.done && mrsp.prod[63:0] < bound_r) dstart = 1'b1;
      S_RDIV: if (ddone && tmp_r < drem) begin
        mreq.start = 1'b1; mreq.a = w1_r; mreq.b = 64'd5;
      end
      default: ;
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SM_C;
      seed_r      <= '0;
      acc_r       <= xrg_pkg::SM_GAMMA;
      cmd_r       <= xrg_pkg::CMD_RAW;
      idx_r       <= '0;
      out_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) seed_r <= cfg_wdata;
      if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
        out_r       <= res_r;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: if (in_valid) begin
          cmd_r   <= in_command;
          lo_r    <= in_range_low;
          bound_r <= span;
          res_r   <= (in_command == xrg_pkg::CMD_RANGE && span_one) ? in_range_low : '0;
          case (in_command)
            xrg_pkg::CMD_RAW: state_r <= S_DR1;
            xrg_pkg::CMD_RANGE: state_r <= span_ok ? S_DR1 : S_OUT;
            xrg_pkg::CMD_JUMP, xrg_pkg::CMD_LJUMP: begin
              long_r <= in_command == xrg_pkg::CMD_LJUMP;
              bit_r <= '0;
              {a0_r, a1_r, a2_r, a3_r} <= '0;
              state_r <= S_JUMP;
            end
            xrg_pkg::CMD_SEED: state_r <= S_SM_C;
            default: state_r <= S_OUT;
          endcase
        end
        S_SM_C: begin
          acc_r   <= seed_r + xrg_pkg::SM_GAMMA;
          idx_r   <= '0;
          state_r <= S_SM_A;
        end
        S_SM_A: if (mrsp.done) state_r <= S_SM_B;
        S_SM_B: if (mrsp.done) begin
          case (idx_r)
            2'd0: w0_r <= z ^ (z >> 31);
            2'd1: w1_r <= z ^ (z >> 31);
            2'd2: w2_r <= z ^ (z >> 31);
            default: w3_r <= z ^ (z >> 31);
          endcase
          idx_r <= idx_r + 2'd1;
          acc_r <= acc_r + xrg_pkg::SM_GAMMA;
          if (idx_r == 2'd3) state_r <= (cmd_r == xrg_pkg::CMD_SEED) ? S_OUT : S_IDLE;
          else state_r <= S_SM_A;
        end
        S_DR1: if (mrsp.done) state_r <= S_DR2;
        S_DR2: if (mrsp.done) begin
          {w0_r, w1_r, w2_r, w3_r} <= {n0, n1, n2, n3};
          if (cmd_r == xrg_pkg::CMD_RANGE) state_r <= S_RMUL;
          else begin
            res_r   <= z;
            state_r <= S_OUT;
          end
        end
        S_RMUL: if (mrsp.done) begin
          tmp_r <= mrsp.prod[63:0];
          res_r <= lo_r + mrsp.prod[127:64];
          if (mrsp.prod[63:0] >= bound_r) state_r <= S_OUT;
          else state_r <= S_RDIV;
        end
        // redraw when the sample falls below the rejection threshold
        S_RDIV: if (ddone) begin
          if (tmp_r >= drem) state_r <= S_OUT;
          else state_r <= S_DR1;
        end
        // jump bits: fold in on set bits and step; on the last bit load the accumulated state
        S_JUMP: begin
          if (bit_r == 8'd255) begin
            w0_r <= a0_r ^ (pbit ? w0_r : 64'd0);
            w1_r <= a1_r ^ (pbit ? w1_r : 64'd0);
            w2_r <= a2_r ^ (pbit ? w2_r : 64'd0);
            w3_r <= a3_r ^ (pbit ? w3_r : 64'd0);
            state_r <= S_OUT;
          end else begin
            if (pbit) begin
              a0_r <= a0_r ^ w0_r; a1_r <= a1_r ^ w1_r;
              a2_r <= a2_r ^ w2_r; a3_r <= a3_r ^ w3_r;
            end
            {w0_r, w1_r, w2_r, w3_r} <= {n0, n1, n2, n3};
            bit_r <= bit_r + 8'd1;
          end
        end
        S_OUT: if (!out_valid_r || !out_stall) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_value = out_r;

  // a stalled result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value));

  // one request at a time
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall);

  // no multiplier answer while idle
  a_mul_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !mrsp.done);
endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int STALL_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [63:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_command;
  logic [63:0] in_range_low;
  logic [63:0] in_range_high;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_value;

  // predictor state
  logic [63:0] gen_word [4];
  logic [63:0] seed_reg;
  logic [63:0] value_queue [$];
  int          error_count;
  bit          quiet_mode;
  int          idle_cycles;

  xoshiro_random_generator_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_range_low (in_range_low),
    .in_range_high(in_range_high),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] rotl(logic [63:0] x, int k);
    return (x << k) | (x >> (64 - k));
  endfunction

  // splitmix64 expansion of the seed
  function automatic void load_from_seed();
    logic [63:0] acc;
    logic [63:0] z;
    acc = seed_reg;
    for (int i = 0; i < 4; i++) begin
      acc = acc + xrg_pkg::SM_GAMMA;
      z = acc;
      z = (z ^ (z >> 30)) * xrg_pkg::SM_MUL1;
      z = (z ^ (z >> 27)) * xrg_pkg::SM_MUL2;
      gen_word[i] = z ^ (z >> 31);
    end
  endfunction

  // one xoshiro256** step
  function automatic logic [63:0] advance_gen();
    logic [63:0] res;
    logic [63:0] t;
    res = rotl(gen_word[1] * 64'd5, 7) * 64'd9;
    t = gen_word[1] << 17;
    gen_word[2] ^= gen_word[0];
    gen_word[3] ^= gen_word[1];
    gen_word[1] ^= gen_word[2];
    gen_word[0] ^= gen_word[3];
    gen_word[2] ^= t;
    gen_word[3] = rotl(gen_word[3], 45);
    return res;
  endfunction

  function automatic logic [63:0] lemire_draw(logic [63:0] bound);
    logic [127:0] prod;
    logic [63:0]  thresh;
    logic [63:0]  dummy;
    if (bound <= 64'd1) return 64'd0;
    thresh = (64'd0 - bound) % bound;
    forever begin
      dummy = advance_gen();
      prod = {64'd0, dummy} * {64'd0, bound};
      if (prod[63:0] >= bound || prod[63:0] >= thresh) return prod[127:64];
    end
  endfunction

  function automatic void jump_gen(logic [255:0] poly);
    logic [63:0] acc [4];
    logic [63:0] dummy;
    for (int k = 0; k < 4; k++) acc[k] = '0;
    for (int b = 0; b < 256; b++) begin
      if (poly[b]) for (int k = 0; k < 4; k++) acc[k] ^= gen_word[k];
      dummy = advance_gen();
    end
    for (int k = 0; k < 4; k++) gen_word[k] = acc[k];
  endfunction

  function automatic logic [63:0] predict_value(logic [2:0] cmd, logic [63:0] lo,
                                                 logic [63:0] hi);
    logic [63:0] r;
    r = '0;
    case (cmd)
      xrg_pkg::CMD_RAW:   r = advance_gen();
      xrg_pkg::CMD_RANGE: if (hi > lo) r = lo + lemire_draw(hi - lo);
      xrg_pkg::CMD_JUMP:  jump_gen(xrg_pkg::JUMP_POLY);
      xrg_pkg::CMD_LJUMP: jump_gen(xrg_pkg::LJUMP_POLY);
      xrg_pkg::CMD_SEED:  load_from_seed();
      default:            r = '0;
    endcase
    return r;
  endfunction

  // send one request and record its expected value
  task automatic send_request(logic [2:0] cmd, logic [63:0] lo, logic [63:0] hi);
    if (!quiet_mode) begin
      while ($urandom_range(0, 99) < 8) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_range_low  <= lo;
    in_range_high <= hi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    value_queue.push_back(predict_value(cmd, lo, hi));
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (value_queue.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_seed(logic [63:0] s);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we   <= 1'b0;
    seed_reg  = s;
  endtask

  // result stall and checking
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (value_queue.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %h", $time, out_value);
          error_count++;
        end else begin
          if (out_value !== value_queue[0]) begin
            $display("%0t value mismatch: expected %h, actual %h", $time,
                     value_queue[0], out_value);
            error_count++;
          end
          void'(value_queue.pop_front());
        end
      end
      out_stall <= quiet_mode ? 1'b0 : ($urandom_range(0, 99) < 8);
    end
  end

  // watchdog on accepted traffic
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_raw_draws();
    for (int i = 0; i < 4; i++) send_request(xrg_pkg::CMD_RAW, rand64(), rand64());
  endtask

  task automatic test_range_edges();
    send_request(xrg_pkg::CMD_RANGE, 64'd10, 64'd10);
    send_request(xrg_pkg::CMD_RANGE, 64'd20, 64'd5);
    send_request(xrg_pkg::CMD_RANGE, 64'd7, 64'd8);
    send_request(xrg_pkg::CMD_RANGE, 64'd0, 64'd2);
    send_request(xrg_pkg::CMD_RANGE, 64'd0, '1);
    send_request(xrg_pkg::CMD_RANGE, '1, 64'd0);
    send_request(xrg_pkg::CMD_RANGE, 64'd0, 64'd3);
    send_request(xrg_pkg::CMD_RANGE, 64'h8000_0000_0000_0000, '1);
    send_request(xrg_pkg::CMD_RANGE, 64'd0, 64'h8000_0000_0000_0001);
  endtask

  task automatic test_jumps_and_reseed();
    send_request(xrg_pkg::CMD_JUMP, '0, '0);
    send_request(xrg_pkg::CMD_RAW, '0, '0);
    send_request(xrg_pkg::CMD_LJUMP, '1, '1);
    send_request(xrg_pkg::CMD_RAW, '0, '0);
    send_request(xrg_pkg::CMD_SEED, '0, '0);
    send_request(xrg_pkg::CMD_RAW, '0, '0);
  endtask

  task automatic test_unknown_commands();
    for (int c = 5; c < 8; c++) send_request(3'(c), rand64(), rand64());
  endtask

  task automatic test_seed_settings();
    write_seed('1);
    send_request(xrg_pkg::CMD_SEED, '0, '0);
    send_request(xrg_pkg::CMD_RAW, '0, '0);
    write_seed(rand64());
    send_request(xrg_pkg::CMD_SEED, '0, '0);
    send_request(xrg_pkg::CMD_RAW, '0, '0);
  endtask

  task automatic test_random_mix(int count);
    int          pick;
    logic [63:0] lo;
    logic [63:0] hi;
    for (int i = 0; i < count; i++) begin
      quiet_mode = (i >= count / 3 && i < count / 2);
      pick = $urandom_range(0, 99);
      lo = rand64();
      hi = rand64();
      if (pick < 35) begin
        send_request(xrg_pkg::CMD_RAW, lo, hi);
      end else if (pick < 80) begin
        // sometimes narrow spans, sometimes 32-bit ones, otherwise random bounds
        case ($urandom_range(0, 3))
          0: hi = lo + 64'($urandom_range(0, 20));
          1: hi = lo + 64'($urandom());
          default: ;
        endcase
        send_request(xrg_pkg::CMD_RANGE, lo, hi);
      end else if (pick < 86) begin
        send_request(xrg_pkg::CMD_JUMP, lo, hi);
      end else if (pick < 91) begin
        send_request(xrg_pkg::CMD_LJUMP, lo, hi);
      end else if (pick < 96) begin
        send_request(xrg_pkg::CMD_SEED, lo, hi);
      end else begin
        send_request(3'($urandom_range(5, 7)), lo, hi);
      end
      if (i == count / 2) drain_results();
      if (i == (count * 3) / 4) write_seed(rand64());
    end
    quiet_mode = 1'b0;
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    in_command    <= xrg_pkg::CMD_RAW;
    in_range_low  <= '0;
    in_range_high <= '0;
    error_count   = 0;
    quiet_mode    = 1'b0;
    seed_reg      = '0;
    load_from_seed();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_raw_draws();
    test_range_edges();
    test_jumps_and_reseed();
    test_unknown_commands();
    test_seed_settings();
    write_seed('0);
    test_random_mix(525);
    drain_results();

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[xoshiro_random_generator_unit.f]
hdl/xrg_pkg.sv
hdl/xrg_mul.sv
hdl/xrg_div.sv
hdl/xoshiro_random_generator_unit.sv
tb/testbench.sv
